// ----- design/gmm_min_distance_pixel_classifier_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pixel classifier
// Clocked implication checks with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef GMM_MIN_DISTANCE_PIXEL_CLASSIFIER_MACROS_SVH
`define GMM_MIN_DISTANCE_PIXEL_CLASSIFIER_MACROS_SVH

// Same-cycle implication: when a holds, b holds.
`define GMMPC_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("gmmpc: same-cycle check failed");

// Next-cycle implication: when a holds, b holds in the next cycle.
`define GMMPC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("gmmpc: next-cycle check failed");

`endif

// ----- design/gmmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// gmmpc_pkg
// Shared types and constants of the pixel classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gmmpc_pkg;

  localparam int MAX_COMPONENTS_DEF = 8;
  localparam int CHANNELS_DEF       = 3;
  localparam int PIXEL_CHANNELS     = 3;

  localparam int SAMPLE_W  = 8;
  localparam int MEAN_W    = 16;
  localparam int SCALE_W   = 32;
  localparam int ENTRY_W   = MEAN_W + SCALE_W;
  localparam int SQ_W      = 2 * MEAN_W;
  localparam int PROD_W    = SQ_W + SCALE_W;
  localparam int FRAC_DROP = 24;
  localparam int TERM_W    = PROD_W - FRAC_DROP;
  localparam int SUM_W     = TERM_W + 2;     // up to four channel terms
  localparam int DIST_W    = 32;
  localparam int COUNT_W   = 4;
  localparam int COMP_IDX_W = 3;
  localparam int CHAN_IDX_W = 2;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  // item kinds on tuser
  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_LOAD     = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic start;   // latch pixel, preset minimum
    logic load;    // write one table entry
    logic rd_en;   // read one component row
    logic emit;    // move minimum into output register
  } dp_cmd_t;

  typedef struct packed {
    logic busy;      // pipeline holds work
    logic out_free;  // output register can take a result
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/gmm_min_distance_pixel_classifier.sv -----
// Load item: no result; the block is ready again next cycle.
// Classify item: N = min(component_count, MAX_COMPONENTS) rows read, one component per
//   cycle, then the five-stage difference/square/scale/sum/minimum pipeline drains;
//   the minimum then moves to the output register, and the next item is taken after
//   that; both wait for as long as an earlier result waits at the output.
// Reset (rst, synchronous): threshold 0, count 5, sequencer idle, table undefined.
// ----------------------------------------------------------------------------
// gmm_min_distance_pixel_classifier
// Nearest-Gaussian threshold classifier of RGB pixels, diagonal Mahalanobis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmm_min_distance_pixel_classifier #(
  parameter int MAX_COMPONENTS = gmmpc_pkg::MAX_COMPONENTS_DEF,   // 1 .. 8
  parameter int CHANNELS       = gmmpc_pkg::CHANNELS_DEF          // 1 .. 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input items
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // red[7:0], green[15:8], blue[23:16], component_index[26:24],
  // channel_index[28:27], mean_value[44:29], inverse_scale[76:45], zero fill
  input  wire logic [gmmpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // command[0]: 0 classify, 1 load entry
  input  wire logic                                s_axis_tuser,
  // result items
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // pixel_class[0], min_distance[32:1], zero fill
  output      logic [gmmpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [gmmpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gmmpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  `include "gmm_min_distance_pixel_classifier_macros.svh"

  localparam int AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  // Configuration registers; the user must write them only while no item is in flight, the block does not enforce it.
  logic [gmmpc_pkg::DIST_W-1:0]  distance_threshold;
  logic [gmmpc_pkg::COUNT_W-1:0] component_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_threshold <= '0;
      component_count    <= gmmpc_pkg::COUNT_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        gmmpc_pkg::REG_THRESHOLD: distance_threshold <= cfg_data;
        gmmpc_pkg::REG_COUNT:     component_count <= cfg_data[gmmpc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack of the input item
  logic [gmmpc_pkg::SAMPLE_W-1:0]   red, green, blue;
  logic [gmmpc_pkg::COMP_IDX_W-1:0] component_index;
  logic [gmmpc_pkg::CHAN_IDX_W-1:0] channel_index;
  logic [gmmpc_pkg::MEAN_W-1:0]     mean_value;
  logic [gmmpc_pkg::SCALE_W-1:0]    inverse_scale;

  assign red             = s_axis_tdata[7:0];
  assign green           = s_axis_tdata[15:8];
  assign blue            = s_axis_tdata[23:16];
  assign component_index = s_axis_tdata[26:24];
  assign channel_index   = s_axis_tdata[28:27];
  assign mean_value      = s_axis_tdata[44:29];
  assign inverse_scale   = s_axis_tdata[76:45];

  gmmpc_pkg::dp_cmd_t  dp_cmd;
  gmmpc_pkg::dp_stat_t dp_stat;
  logic [AW-1:0]       rd_addr;
  logic                pixel_class;
  logic [gmmpc_pkg::DIST_W-1:0] min_distance;

  // Sequencer: one table row per cycle, then drain and hand over the minimum.
  gmmpc_ctrl #(
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .count    (component_count),
    .stat     (dp_stat),
    .cmd      (dp_cmd),
    .rd_addr  (rd_addr)
  );

  // Table per channel, distance lanes, minimum and the output register.
  gmmpc_dp #(
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .CHANNELS       (CHANNELS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (dp_cmd),
    .rd_addr         (rd_addr),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .component_index (component_index),
    .channel_index   (channel_index),
    .mean_value      (mean_value),
    .inverse_scale   (inverse_scale),
    .threshold       (distance_threshold),
    .stat            (dp_stat),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_class       (pixel_class),
    .out_dist        (min_distance)
  );

  assign m_axis_tdata = {7'd0, min_distance, pixel_class};

  // While the lanes still hold work no new item may enter.
  `GMMPC_ASSERT_IMPL(a_busy_blocks_input, clk, rst, dp_stat.busy, !s_axis_tready)
  // A result is never written over one that has not been taken.
  `GMMPC_ASSERT_IMPL(a_emit_into_free_slot, clk, rst, dp_cmd.emit, dp_stat.out_free)
  // A load item gives no result.
  `GMMPC_ASSERT_NEXT(a_load_no_result, clk, rst,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == gmmpc_pkg::CMD_LOAD) && !m_axis_tvalid,
    !m_axis_tvalid)

endmodule

`default_nettype wire

// ----- design/gmmpc_ram.sv -----
// ----------------------------------------------------------------------------
// gmmpc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmmpc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          raddr,
  output      logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/gmmpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// gmmpc_ctrl
// Sequencer: takes items, walks the active components, hands out results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmmpc_ctrl #(
  parameter int MAX_COMPONENTS = gmmpc_pkg::MAX_COMPONENTS_DEF,
  localparam int AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_kind,
  output      logic                          in_ready,
  input  wire logic [gmmpc_pkg::COUNT_W-1:0] count,
  input  wire gmmpc_pkg::dp_stat_t           stat,
  output      gmmpc_pkg::dp_cmd_t            cmd,
  output      logic [AW-1:0]                 rd_addr
);

  localparam int CW = $clog2(MAX_COMPONENTS + 1);

  gmmpc_pkg::ctrl_state_t state, state_next;
  logic [AW-1:0] k, k_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] cnt_eff;
  logic          accept;

  assign cnt_eff = (32'(count) > 32'(MAX_COMPONENTS)) ? CW'(MAX_COMPONENTS) : CW'(count);
  assign rd_addr = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gmmpc_pkg::ST_IDLE;
      k     <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    accept     = 1'b0;
    unique case (state)
      gmmpc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept) begin
          if (in_kind == gmmpc_pkg::CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            k_next    = '0;
            cnt_next  = cnt_eff;
            state_next = (cnt_eff == '0) ? gmmpc_pkg::ST_EMIT : gmmpc_pkg::ST_ISSUE;
          end
        end
      end
      gmmpc_pkg::ST_ISSUE: begin
        cmd.rd_en = 1'b1;
        if ((CW'(k) + 1'b1) == cnt) begin
          state_next = gmmpc_pkg::ST_DRAIN;
        end else begin
          k_next = k + 1'b1;
        end
      end
      gmmpc_pkg::ST_DRAIN: begin
        if (!stat.busy) begin
          state_next = gmmpc_pkg::ST_EMIT;
        end
      end
      gmmpc_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = gmmpc_pkg::ST_IDLE;
        end
      end
      default: state_next = gmmpc_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/gmmpc_dp.sv -----
// ----------------------------------------------------------------------------
// gmmpc_dp
// Component table, per-channel distance lanes, running minimum, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmmpc_dp #(
  parameter int MAX_COMPONENTS = gmmpc_pkg::MAX_COMPONENTS_DEF,
  parameter int CHANNELS       = gmmpc_pkg::CHANNELS_DEF,
  localparam int AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire gmmpc_pkg::dp_cmd_t               cmd,
  input  wire logic [AW-1:0]                    rd_addr,
  input  wire logic [gmmpc_pkg::SAMPLE_W-1:0]   red,
  input  wire logic [gmmpc_pkg::SAMPLE_W-1:0]   green,
  input  wire logic [gmmpc_pkg::SAMPLE_W-1:0]   blue,
  input  wire logic [gmmpc_pkg::COMP_IDX_W-1:0] component_index,
  input  wire logic [gmmpc_pkg::CHAN_IDX_W-1:0] channel_index,
  input  wire logic [gmmpc_pkg::MEAN_W-1:0]     mean_value,
  input  wire logic [gmmpc_pkg::SCALE_W-1:0]    inverse_scale,
  input  wire logic [gmmpc_pkg::DIST_W-1:0]     threshold,
  output      gmmpc_pkg::dp_stat_t              stat,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic                             out_class,
  output      logic [gmmpc_pkg::DIST_W-1:0]     out_dist
);

  localparam int SW = gmmpc_pkg::SAMPLE_W;
  localparam int MW = gmmpc_pkg::MEAN_W;
  localparam int KW = gmmpc_pkg::SCALE_W;

  logic [SW-1:0] smp [gmmpc_pkg::PIXEL_CHANNELS];

  logic [4:0] vld;      // rdata, diff, square, product, sum
  logic       comp_ok;
  logic [AW-1:0] waddr;
  logic [AW+gmmpc_pkg::COMP_IDX_W-1:0] waddr_ext;

  logic [gmmpc_pkg::TERM_W-1:0] term [CHANNELS];
  logic [gmmpc_pkg::SUM_W-1:0]  sum_comb, sum_q;
  logic [gmmpc_pkg::DIST_W-1:0] dist_sat, best;

  assign comp_ok   = 32'(component_index) < 32'(MAX_COMPONENTS);
  assign waddr_ext = {{AW{1'b0}}, component_index};
  assign waddr     = waddr_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      smp[0] <= red;
      smp[1] <= green;
      smp[2] <= blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], cmd.rd_en};
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic [gmmpc_pkg::ENTRY_W-1:0] rdata;
    logic [SW-1:0]                 s;
    logic [MW-1:0]                 x, m, d;
    logic [MW-1:0]                 d_a;
    logic [KW-1:0]                 scale_a, scale_b;
    logic [gmmpc_pkg::SQ_W-1:0]    sq_b;
    logic [gmmpc_pkg::PROD_W-1:0]  prod;

    gmmpc_ram #(
      .WIDTH (gmmpc_pkg::ENTRY_W),
      .DEPTH (MAX_COMPONENTS)
    ) u_ram (
      .clk   (clk),
      .we    (cmd.load && comp_ok && (channel_index == gmmpc_pkg::CHAN_IDX_W'(c))),
      .waddr (waddr),
      .wdata ({inverse_scale, mean_value}),
      .re    (cmd.rd_en),
      .raddr (rd_addr),
      .rdata (rdata)
    );

    if (c < gmmpc_pkg::PIXEL_CHANNELS) begin : g_smp
      assign s = smp[c];
    end else begin : g_zero
      assign s = '0;
    end

    assign x = {s, 8'h00};
    assign m = rdata[MW-1:0];
    assign d = (x >= m) ? (x - m) : (m - x);
    assign prod = sq_b * scale_b;

    always_ff @(posedge clk) begin
      d_a     <= d;
      scale_a <= rdata[gmmpc_pkg::ENTRY_W-1:MW];
      sq_b    <= d_a * d_a;
      scale_b <= scale_a;
      term[c] <= prod[gmmpc_pkg::PROD_W-1:gmmpc_pkg::FRAC_DROP];
    end
  end

  always_comb begin
    sum_comb = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sum_comb = sum_comb + gmmpc_pkg::SUM_W'(term[c]);
    end
  end

  assign dist_sat = (|sum_q[gmmpc_pkg::SUM_W-1:gmmpc_pkg::DIST_W]) ?
                    gmmpc_pkg::DIST_SAT : sum_q[gmmpc_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    sum_q <= sum_comb;
    if (cmd.start) begin
      best <= gmmpc_pkg::DIST_SAT;
    end else if (vld[4] && (dist_sat < best)) begin
      best <= dist_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dist  <= best;
      out_class <= (best <= threshold);
    end
  end

  assign stat.busy     = |vld;
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire
